// File: sv/cti_pkg.sv
// Package for the cook timer interlock controller.
// Holds the item layouts, phase encodings and constants.
// No dependencies.
package cti_pkg;

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 32;

  localparam logic [3:0] KeyEnter  = 4'd10;
  localparam logic [3:0] KeyDelete = 4'd11;
  localparam logic [3:0] DecBase   = 4'd10;
  localparam logic [5:0] EntryMax  = 6'd60;
  localparam logic [4:0] LoadSteps = 5'd16;

  typedef enum logic [2:0] {
    SETUP_LOADING = 3'd0,
    SETUP_PROMPT  = 3'd1,
    SETUP_MINUTES = 3'd2,
    SETUP_SECONDS = 3'd3,
    SETUP_SHOW    = 3'd4,
    SETUP_AWAIT   = 3'd5,
    SETUP_DONE    = 3'd6
  } setup_phase_e;

  typedef enum logic [1:0] {
    RUN_CHECK    = 2'd0,
    RUN_PREPARE  = 2'd1,
    RUN_COUNTING = 2'd2,
    RUN_FINISHED = 2'd3
  } run_phase_e;

  // first field in the highest bits
  typedef struct packed {
    logic       second_tick;
    logic       setup_tick;
    logic       weight_ok;
    logic       door_closed;
    logic       cancel_pressed;
    logic       start_pressed;
    logic [3:0] key_code;
    logic       key_valid;
  } in_item_t;

  typedef struct packed {
    logic       interlock_fault;
    logic [1:0] run_phase;
    logic [2:0] setup_phase;
    logic       time_confirmed;
    logic       buzzer_on;
    logic       lamp_on;
    logic       motor_on;
    logic       heater_on;
    logic [5:0] entry_value;
    logic [5:0] seconds_left;
    logic [5:0] minutes_left;
  } out_item_t;

  localparam int unsigned InItemW  = $bits(in_item_t);
  localparam int unsigned OutItemW = $bits(out_item_t);

endpackage

// File: sv/cook_timer_interlock_controller.sv
// Cook timer interlock controller: keypad entry, setup sequence, run sequence.
// Depends on cti_pkg.
//
// One item is one controller tick. The block takes one item per clock cycle
// while the output is not stalled; each item goes through one input
// register, then the whole tick update in one pass of logic into the result
// register and the state registers. The rate is set by that single pass:
// every state register is updated in the cycle its item leaves the input
// register, so the next item sees it at once. A stalled output holds the
// result and, once both registers are full, stops accepting input.
module cook_timer_interlock_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] key_valid, [4:1] key_code, [5] start_pressed, [6] cancel_pressed,
  // [7] door_closed, [8] weight_ok, [9] setup_tick, [10] second_tick, rest zero
  input  logic [cti_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] minutes_left, [11:6] seconds_left, [17:12] entry_value,
  // [18] heater_on, [19] motor_on, [20] lamp_on, [21] buzzer_on,
  // [22] time_confirmed, [25:23] setup_phase, [27:26] run_phase,
  // [28] interlock_fault, rest zero
  output logic [cti_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import cti_pkg::*;

  logic         in_valid_q;
  in_item_t     in_q;
  logic         out_valid_q;
  out_item_t    out_q;
  logic         adv;
  logic         fire;

  setup_phase_e setup_q, setup_d;
  run_phase_e   run_q, run_d;
  logic [4:0]   load_q, load_d;
  logic [5:0]   min_q, min_d;
  logic [5:0]   sec_q, sec_d;
  logic [5:0]   entry_q, entry_d;
  logic         enter_q, enter_d;
  logic         start_q, start_d;
  logic         cancel_q, cancel_d;
  logic         min_saved_q, min_saved_d;
  logic         sec_saved_q, sec_saved_d;
  logic         conf_q, conf_d;
  logic         heater_q, heater_d;
  logic         motor_q, motor_d;
  logic         lamp_q, lamp_d;
  logic         buzzer_q, buzzer_d;
  logic         fault_q, fault_d;
  logic         restart_q, restart_d;

  logic [9:0]   digit_val;
  logic [13:0]  div_prod;
  logic         good;
  out_item_t    res;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign good          = in_q.door_closed && in_q.weight_ok;

  // entry*10+digit and entry/10 (x*205 >> 11 is exact for 6-bit x)
  assign digit_val = 10'(entry_q) * 10'(DecBase) + 10'(in_q.key_code);
  assign div_prod  = 14'(entry_q) * 14'd205;

  always_comb begin
    setup_d     = setup_q;
    run_d       = run_q;
    load_d      = load_q;
    min_d       = min_q;
    sec_d       = sec_q;
    entry_d     = entry_q;
    enter_d     = enter_q;
    start_d     = start_q;
    cancel_d    = cancel_q;
    min_saved_d = min_saved_q;
    sec_saved_d = sec_saved_q;
    conf_d      = conf_q;
    heater_d    = heater_q;
    motor_d     = motor_q;
    lamp_d      = lamp_q;
    buzzer_d    = buzzer_q;
    fault_d     = fault_q;
    restart_d   = restart_q;

    if (fire) begin
      if (in_q.start_pressed) start_d = 1'b1;
      if (in_q.cancel_pressed) cancel_d = 1'b1;

      // keypad
      if (in_q.key_valid) begin
        if (in_q.key_code == KeyEnter) begin
          enter_d = 1'b1;
        end else if (in_q.key_code == KeyDelete) begin
          entry_d = 6'(div_prod[13:11]);
        end else if (in_q.key_code < DecBase) begin
          if (entry_q < EntryMax) begin
            entry_d = (digit_val > 10'(EntryMax)) ? EntryMax : digit_val[5:0];
          end
        end
      end

      // setup sequence
      if (in_q.setup_tick) begin
        if (restart_d) begin
          restart_d = 1'b0;
          setup_d   = SETUP_PROMPT;
        end
        case (setup_d)
          SETUP_LOADING: begin
            if (load_d != 5'h1f) load_d = load_d + 5'd1;
            if (load_d >= LoadSteps) setup_d = SETUP_PROMPT;
          end
          SETUP_PROMPT: begin
            min_d       = '0;
            sec_d       = '0;
            conf_d      = 1'b0;
            min_saved_d = 1'b0;
            sec_saved_d = 1'b0;
            setup_d     = SETUP_MINUTES;
          end
          SETUP_MINUTES: begin
            if (enter_d) begin
              min_d       = entry_d;
              min_saved_d = 1'b1;
              entry_d     = '0;
              enter_d     = 1'b0;
              start_d     = 1'b0;
              cancel_d    = 1'b0;
              setup_d     = SETUP_SECONDS;
            end
          end
          SETUP_SECONDS: begin
            if (enter_d && (entry_d != '0 || min_d != '0)) begin
              sec_d       = entry_d;
              sec_saved_d = 1'b1;
              entry_d     = '0;
              enter_d     = 1'b0;
              start_d     = 1'b0;
              cancel_d    = 1'b0;
              setup_d     = SETUP_SHOW;
            end
          end
          SETUP_SHOW: begin
            setup_d = SETUP_AWAIT;
          end
          SETUP_AWAIT: begin
            if (start_d) begin
              conf_d  = 1'b1;
              setup_d = SETUP_DONE;
            end else if (cancel_d) begin
              setup_d = SETUP_PROMPT;
            end
          end
          default: begin
          end
        endcase
      end

      // run sequence, only once the time is confirmed
      if (in_q.second_tick && conf_d) begin
        case (run_d)
          RUN_CHECK: begin
            if (good) run_d = RUN_COUNTING;
          end
          RUN_PREPARE: begin
            run_d = RUN_COUNTING;
          end
          RUN_COUNTING: begin
            if (min_d != '0 || sec_d != '0) begin
              if (good) begin
                heater_d = 1'b1;
                motor_d  = 1'b1;
                fault_d  = 1'b0;
                if (sec_d == '0) begin
                  sec_d = EntryMax - 6'd1;
                  min_d = min_d - 6'd1;
                end else begin
                  sec_d = sec_d - 6'd1;
                end
              end else begin
                heater_d = 1'b0;
                motor_d  = 1'b0;
                fault_d  = 1'b1;
                run_d    = RUN_PREPARE;
              end
            end else begin
              heater_d = 1'b0;
              motor_d  = 1'b0;
              lamp_d   = 1'b1;
              buzzer_d = 1'b1;
              start_d  = 1'b0;
              run_d    = RUN_FINISHED;
            end
          end
          RUN_FINISHED: begin
            if (start_d) begin
              lamp_d    = 1'b0;
              buzzer_d  = 1'b0;
              entry_d   = '0;
              enter_d   = 1'b0;
              cancel_d  = 1'b0;
              fault_d   = 1'b0;
              conf_d    = 1'b0;
              restart_d = 1'b1;
              run_d     = RUN_CHECK;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res                 = '0;
    res.minutes_left    = min_d;
    res.seconds_left    = sec_d;
    res.entry_value     = entry_d;
    res.heater_on       = heater_d;
    res.motor_on        = motor_d;
    res.lamp_on         = lamp_d;
    res.buzzer_on       = buzzer_d;
    res.time_confirmed  = conf_d;
    res.setup_phase     = setup_d;
    res.run_phase       = run_d;
    res.interlock_fault = fault_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      setup_q     <= SETUP_LOADING;
      run_q       <= RUN_CHECK;
      load_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      entry_q     <= '0;
      enter_q     <= 1'b0;
      start_q     <= 1'b0;
      cancel_q    <= 1'b0;
      min_saved_q <= 1'b0;
      sec_saved_q <= 1'b0;
      conf_q      <= 1'b0;
      heater_q    <= 1'b0;
      motor_q     <= 1'b0;
      lamp_q      <= 1'b0;
      buzzer_q    <= 1'b0;
      fault_q     <= 1'b0;
      restart_q   <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) out_valid_q <= in_valid_q;
      setup_q     <= setup_d;
      run_q       <= run_d;
      load_q      <= load_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      entry_q     <= entry_d;
      enter_q     <= enter_d;
      start_q     <= start_d;
      cancel_q    <= cancel_d;
      min_saved_q <= min_saved_d;
      sec_saved_q <= sec_saved_d;
      conf_q      <= conf_d;
      heater_q    <= heater_d;
      motor_q     <= motor_d;
      lamp_q      <= lamp_d;
      buzzer_q    <= buzzer_d;
      fault_q     <= fault_d;
      restart_q   <= restart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= s_axis_tdata[InItemW-1:0];
    if (fire) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW - OutItemW){1'b0}}, out_q};

endmodule

// File: sv/cti_checker.sv
// Port-level checks for the cook timer interlock controller, bound to the controller module.
// Depends on cti_pkg.
module cti_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cti_pkg::OutTdataW-1:0] m_axis_tdata
);
  import cti_pkg::*;

  out_item_t res;
  assign res = m_axis_tdata[OutItemW-1:0];

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // heating only happens while counting a confirmed time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.heater_on |->
      res.time_confirmed && res.run_phase == RUN_COUNTING && res.motor_on)
    else $error("heater on outside a confirmed countdown");

  // finish indication and heating never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.lamp_on |-> !res.heater_on && res.buzzer_on &&
      res.run_phase == RUN_FINISHED)
    else $error("finish lamp out of step with run phase");

  // an interlock fault leaves the drives off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.interlock_fault |-> !res.heater_on && !res.motor_on)
    else $error("drives on during interlock fault");

endmodule

bind cook_timer_interlock_controller cti_checker u_cti_checker (.*);

// File: tb/tb_cook_timer_interlock_controller.sv
// Testbench for cook_timer_interlock_controller: directed and random ticks checked
// field by field against an in-bench model of the keypad, setup and run sequences.
// Depends on cti_pkg and the controller RTL.
module tb_cook_timer_interlock_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import cti_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomTicks  = 1450;
  localparam int unsigned CalmTail     = 150;
  localparam int unsigned HoldCycles   = 80;
  localparam logic [4:0]  LoadCountMax = 5'd31;
  localparam logic [3:0]  KeyUnusedLo  = 4'd12;
  localparam logic [3:0]  KeyUnusedHi  = 4'd15;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  cook_timer_interlock_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // controller model state
  setup_phase_e ck_setup = SETUP_LOADING;
  run_phase_e   ck_run = RUN_CHECK;
  logic [4:0]   ck_load = '0;
  logic [5:0]   ck_min = '0;
  logic [5:0]   ck_sec = '0;
  logic [5:0]   ck_entry = '0;
  logic         ck_enter_pend = 1'b0;
  logic         ck_start_pend = 1'b0;
  logic         ck_cancel_pend = 1'b0;
  logic         ck_min_saved = 1'b0;
  logic         ck_sec_saved = 1'b0;
  logic         ck_confirmed = 1'b0;
  logic         ck_heater = 1'b0;
  logic         ck_motor = 1'b0;
  logic         ck_lamp = 1'b0;
  logic         ck_buzzer = 1'b0;
  logic         ck_fault = 1'b0;
  logic         ck_restart = 1'b0;

  out_item_t status_q[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        idle_en = 1'b1;
  bit        hold_off = 1'b0;
  int        sink_stall = 0;

  function automatic void clear_entry_and_flags();
    ck_entry       = '0;
    ck_enter_pend  = 1'b0;
    ck_start_pend  = 1'b0;
    ck_cancel_pend = 1'b0;
  endfunction

  // One controller tick: buttons, key, setup step, run step; returns the status after it.
  function automatic out_item_t advance_cook_model(in_item_t t);
    out_item_t s;
    int        typed;
    logic      sensors_ok;
    if (t.start_pressed) ck_start_pend = 1'b1;
    if (t.cancel_pressed) ck_cancel_pend = 1'b1;
    if (t.key_valid) begin
      if (t.key_code == KeyEnter) begin
        ck_enter_pend = 1'b1;
      end else if (t.key_code == KeyDelete) begin
        ck_entry = ck_entry / DecBase;
      end else if (t.key_code < DecBase) begin
        if (ck_entry < EntryMax) begin
          typed = int'(ck_entry) * int'(DecBase) + int'(t.key_code);
          ck_entry = (typed > int'(EntryMax)) ? EntryMax : 6'(typed);
        end
      end
    end
    if (t.setup_tick) begin
      if (ck_restart) begin
        ck_restart = 1'b0;
        ck_setup   = SETUP_PROMPT;
      end
      case (ck_setup)
        SETUP_LOADING: begin
          if (ck_load < LoadCountMax) ck_load = ck_load + 5'd1;
          if (ck_load >= LoadSteps) ck_setup = SETUP_PROMPT;
        end
        SETUP_PROMPT: begin
          ck_min       = '0;
          ck_sec       = '0;
          ck_confirmed = 1'b0;
          ck_min_saved = 1'b0;
          ck_sec_saved = 1'b0;
          ck_setup     = SETUP_MINUTES;
        end
        SETUP_MINUTES: begin
          if (ck_enter_pend) begin
            ck_min       = ck_entry;
            ck_min_saved = 1'b1;
            clear_entry_and_flags();
            ck_setup     = SETUP_SECONDS;
          end
        end
        SETUP_SECONDS: begin
          if (ck_enter_pend && (ck_entry != 0 || ck_min != 0)) begin
            ck_sec       = ck_entry;
            ck_sec_saved = 1'b1;
            clear_entry_and_flags();
            ck_setup     = SETUP_SHOW;
          end
        end
        SETUP_SHOW: ck_setup = SETUP_AWAIT;
        SETUP_AWAIT: begin
          if (ck_start_pend) begin
            ck_confirmed = 1'b1;
            ck_setup     = SETUP_DONE;
          end else if (ck_cancel_pend) begin
            ck_setup = SETUP_PROMPT;
          end
        end
        default: ;
      endcase
    end
    if (t.second_tick && ck_confirmed) begin
      sensors_ok = t.door_closed && t.weight_ok;
      case (ck_run)
        RUN_CHECK: if (sensors_ok) ck_run = RUN_COUNTING;
        RUN_PREPARE: ck_run = RUN_COUNTING;
        RUN_COUNTING: begin
          if (ck_min != 0 || ck_sec != 0) begin
            if (sensors_ok) begin
              ck_heater = 1'b1;
              ck_motor  = 1'b1;
              ck_fault  = 1'b0;
              if (ck_sec == 0) begin
                ck_sec = EntryMax;
                ck_min = ck_min - 6'd1;
              end
              ck_sec = ck_sec - 6'd1;
            end else begin
              ck_heater = 1'b0;
              ck_motor  = 1'b0;
              ck_fault  = 1'b1;
              ck_run    = RUN_PREPARE;
            end
          end else begin
            // done: only lamp and buzzer stay on
            ck_heater     = 1'b0;
            ck_motor      = 1'b0;
            ck_lamp       = 1'b1;
            ck_buzzer     = 1'b1;
            ck_start_pend = 1'b0;
            ck_run        = RUN_FINISHED;
          end
        end
        default: begin
          if (ck_start_pend) begin
            ck_lamp        = 1'b0;
            ck_buzzer      = 1'b0;
            ck_entry       = '0;
            ck_enter_pend  = 1'b0;
            ck_cancel_pend = 1'b0;
            ck_fault       = 1'b0;
            ck_confirmed   = 1'b0;
            ck_restart     = 1'b1;
            ck_run         = RUN_CHECK;
          end
        end
      endcase
    end
    s.minutes_left    = ck_min;
    s.seconds_left    = ck_sec;
    s.entry_value     = ck_entry;
    s.heater_on       = ck_heater;
    s.motor_on        = ck_motor;
    s.lamp_on         = ck_lamp;
    s.buzzer_on       = ck_buzzer;
    s.time_confirmed  = ck_confirmed;
    s.setup_phase     = ck_setup;
    s.run_phase       = ck_run;
    s.interlock_fault = ck_fault;
    return s;
  endfunction

  task automatic send_tick(in_item_t t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InTdataW'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW - InItemW){1'b0}}, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    status_q.push_back(advance_cook_model(t));
    @(negedge clk_i);
  endtask

  function automatic in_item_t calm_tick();
    in_item_t t;
    t = '0;
    t.door_closed = 1'b1;
    t.weight_ok   = 1'b1;
    return t;
  endfunction

  task automatic send_key(logic [3:0] code, bit with_setup);
    in_item_t t;
    t = calm_tick();
    t.key_valid  = 1'b1;
    t.key_code   = code;
    t.setup_tick = with_setup;
    send_tick(t);
  endtask

  task automatic step_setup();
    in_item_t t;
    t = calm_tick();
    t.setup_tick = 1'b1;
    send_tick(t);
  endtask

  task automatic run_second(bit door, bit weight);
    in_item_t t;
    t = calm_tick();
    t.second_tick = 1'b1;
    t.door_closed = door;
    t.weight_ok   = weight;
    send_tick(t);
  endtask

  // Power-up count, digit clamp, delete, unused codes, run step while unconfirmed.
  task automatic test_loading_and_keypad();
    in_item_t t;
    t = '0;
    send_tick(t);
    t = calm_tick();
    t.setup_tick     = 1'b1;
    t.second_tick    = 1'b1;
    t.start_pressed  = 1'b1;
    t.cancel_pressed = 1'b1;
    send_tick(t);
    send_key(4'd9, 1'b1);
    send_key(4'd9, 1'b1);
    send_key(4'd5, 1'b1);
    send_key(KeyDelete, 1'b1);
    send_key(KeyUnusedHi, 1'b1);
    send_key(KeyDelete, 1'b1);
    send_key(KeyUnusedLo, 1'b1);
    send_key(4'd0, 1'b1);
    while (ck_setup == SETUP_LOADING) step_setup();
  endtask

  // Zero time refused, 60:xx and xx:60 entries, cancel back to prompt.
  task automatic test_entry_limits();
    in_item_t t;
    step_setup();
    send_key(KeyEnter, 1'b1);
    send_key(KeyEnter, 1'b1);
    send_key(4'd6, 1'b0);
    send_key(4'd5, 1'b0);
    step_setup();
    step_setup();
    run_second(1'b1, 1'b1);
    t = calm_tick();
    t.cancel_pressed = 1'b1;
    t.setup_tick     = 1'b1;
    send_tick(t);
    step_setup();
    send_key(4'd6, 1'b0);
    send_key(4'd7, 1'b0);
    send_key(KeyEnter, 1'b1);
    send_key(4'd9, 1'b0);
    send_key(KeyEnter, 1'b1);
    step_setup();
    send_tick(t);
  endtask

  // Short cook: interlock wait, fault and resume, finish, restart into the prompt.
  task automatic test_interlock_cook();
    in_item_t t;
    step_setup();
    send_key(KeyEnter, 1'b1);
    send_key(4'd3, 1'b0);
    send_key(KeyEnter, 1'b1);
    step_setup();
    t = calm_tick();
    t.start_pressed = 1'b1;
    t.setup_tick    = 1'b1;
    send_tick(t);
    step_setup();
    run_second(1'b0, 1'b1);
    run_second(1'b1, 1'b1);
    run_second(1'b1, 1'b1);
    run_second(1'b1, 1'b0);
    run_second(1'b0, 1'b0);
    repeat (4) run_second(1'b1, 1'b1);
    t = calm_tick();
    t.start_pressed = 1'b1;
    t.second_tick   = 1'b1;
    send_tick(t);
    step_setup();
  endtask

  // Mostly well-formed cook cycles; minute digits mostly 0 or 1 so countdowns stay short.
  function automatic in_item_t pick_cook_tick();
    in_item_t t;
    int       r;
    bit       at_minutes;
    t = '0;
    r = $urandom_range(0, 99);
    at_minutes = (ck_setup == SETUP_MINUTES);
    t.key_valid = ($urandom_range(0, 99) < 45);
    if (at_minutes || ck_setup == SETUP_SECONDS) begin
      if (r < 4) t.key_code = 4'($urandom_range(0, 15));
      else if (at_minutes && ck_entry > 1) t.key_code = KeyDelete;
      else if (r < 35) t.key_code = KeyEnter;
      else t.key_code = 4'($urandom_range(0, at_minutes ? 1 : 9));
    end else begin
      t.key_code = 4'($urandom_range(0, 15));
    end
    t.start_pressed = (ck_setup == SETUP_AWAIT || ck_run == RUN_FINISHED) ?
                      ($urandom_range(0, 99) < 25) : ($urandom_range(0, 99) < 4);
    t.cancel_pressed = ($urandom_range(0, 99) < ((ck_setup == SETUP_AWAIT) ? 10 : 4));
    t.door_closed    = ($urandom_range(0, 99) < 92);
    t.weight_ok      = ($urandom_range(0, 99) < 92);
    // never store a stale large entry as minutes
    t.setup_tick     = !(at_minutes && ck_entry > 1) && ($urandom_range(0, 99) < 60);
    t.second_tick    = ($urandom_range(0, 99) < 70);
    return t;
  endfunction

  task automatic test_random_cooks(int unsigned n_ticks);
    for (int unsigned i = 0; i < n_ticks; i++) begin
      idle_en = (i < n_ticks - CalmTail);
      if (i == n_ticks / 4) begin
        // long output stall while items keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_tick(pick_cook_tick());
    end
  endtask

  always @(negedge clk_i) begin
    if (sink_stall != 0) sink_stall--;
    else if (idle_en && $urandom_range(0, 5) == 0) sink_stall = $urandom_range(1, 9);
    m_axis_tready <= (sink_stall == 0) && !hold_off;
  end

  task automatic check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutItemW-1:0];
      if (status_q.size() == 0) begin
        $error("status item with no expectation: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = status_q.pop_front();
        check_field("minutes_left", want.minutes_left, got.minutes_left);
        check_field("seconds_left", want.seconds_left, got.seconds_left);
        check_field("entry_value", want.entry_value, got.entry_value);
        check_field("heater_on", want.heater_on, got.heater_on);
        check_field("motor_on", want.motor_on, got.motor_on);
        check_field("lamp_on", want.lamp_on, got.lamp_on);
        check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
        check_field("time_confirmed", want.time_confirmed, got.time_confirmed);
        check_field("setup_phase", want.setup_phase, got.setup_phase);
        check_field("run_phase", want.run_phase, got.run_phase);
        check_field("interlock_fault", want.interlock_fault, got.interlock_fault);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_cook_timer_interlock_controller failed");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_loading_and_keypad();
    test_entry_limits();
    test_interlock_cook();
    test_random_cooks(RandomTicks);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (status_q.size() != 0) begin
      $error("%0d status items never arrived", status_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_cook_timer_interlock_controller passed");
    end else begin
      $display("tb_cook_timer_interlock_controller failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/cti_pkg.sv
sv/cook_timer_interlock_controller.sv
sv/cti_checker.sv
tb/tb_cook_timer_interlock_controller.sv
